>>> rtl/tfc_pkg.sv
// Package for the triangular double-to-single converter.
// Holds constants, the result struct and the binary64-to-binary32 rounding function.
// No dependencies.
package tfc_pkg;

    localparam int unsigned MaxSizeDefault = 1024;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgDataW = 11;
    localparam logic [CfgIdxW-1:0] RegUpperSelect = 1'd0;
    localparam logic [CfgIdxW-1:0] RegMatrixSize = 1'd1;
    localparam logic [62:0] F64Inf = 63'h7FF0000000000000;
    localparam logic [62:0] F64FltMax = 63'h47EFFFFFE0000000;

    typedef struct packed {
        logic [31:0] single_bits;
        logic        status;
        logic        last;
    } t_conv;

    function automatic logic [31:0] f64_to_f32(input logic [63:0] d);
        logic        sgn;
        logic [62:0] mag;
        logic [10:0] bexp;
        logic [51:0] frac;
        logic [52:0] sig;
        logic [5:0]  sh;
        logic [52:0] q;
        logic [52:0] rem;
        logic [52:0] half;
        logic [52:0] mask;
        logic        up;
        logic [31:0] res;
        sgn  = d[63];
        mag  = d[62:0];
        bexp = mag[62:52];
        frac = mag[51:0];
        sig  = {1'b1, frac};
        sh   = 6'd0;
        q    = '0;
        rem  = '0;
        half = '0;
        mask = '0;
        up   = 1'b0;
        if (mag > F64Inf) begin
            res = {sgn, 8'hFF, 1'b1, frac[50:29]};
        end else if (bexp == 11'd0) begin
            res = {sgn, 31'd0};
        end else if (bexp >= 11'd897) begin
            up  = frac[28] && ((frac[27:0] != '0) || frac[29]);
            res = {sgn, 31'({bexp - 11'd896, 23'd0} + {12'd0, frac[51:29]} + 31'(up))};
        end else if (bexp < 11'd873) begin
            res = {sgn, 31'd0};
        end else begin
            sh   = 6'(11'd926 - bexp);
            q    = sig >> sh;
            mask = (53'd1 << sh) - 53'd1;
            rem  = sig & mask;
            half = 53'd1 << (sh - 6'd1);
            up   = (rem > half) || ((rem == half) && q[0]);
            res  = {sgn, 31'(q + 53'(up))};
        end
        return res;
    endfunction

endpackage

>>> rtl/triangular_f64_to_f32_convert.sv
// Triangular double-to-single converter, top level.
// Throughput one transaction per cycle while the output is not stalled.
// Input register feeds conversion logic into an output register; stall propagates back.
// Reset (synchronous, active low): upper triangle, size 0, walker at origin, no abort.
// Uses tfc_pkg.
module triangular_f64_to_f32_convert #(
    parameter int unsigned MAX_SIZE = tfc_pkg::MaxSizeDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [63:0]                  i_element_bits,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [31:0]                  o_single_bits,
    output logic [9:0]                   o_row_index,
    output logic [9:0]                   o_col_index,
    output logic                         o_status,
    output logic                         o_last,
    input  logic                         i_cfg_we,
    input  logic [tfc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [tfc_pkg::CfgDataW-1:0] i_cfg_data
);
    localparam int unsigned CntW = $clog2(MAX_SIZE + 1) + 1;

    logic            r_upper;
    logic [10:0]     r_size;
    logic [CntW-1:0] r_row, r_col, n_row, n_col;
    logic            r_abort, n_abort;
    logic            r_s1_v;
    logic [63:0]     r_s1_d;
    logic [9:0]      r_s1_row, r_s1_col;
    logic            r_s1_final;
    logic            r_o_v;
    logic [CntW-1:0] nsz;
    logic            adv1, take_in, final_e, ovf1;
    tfc_pkg::t_conv  conv;

    assign nsz = (32'(r_size) > MAX_SIZE) ? CntW'(MAX_SIZE) : CntW'(r_size);

    assign adv1    = !r_o_v || !i_stall;
    assign o_stall = r_s1_v && !adv1;
    assign take_in = i_valid && !o_stall;
    assign final_e = (r_row == nsz - 1'b1) && (r_col == nsz - 1'b1);

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_abort = r_abort;
        if (r_s1_v && adv1 && !r_abort && ovf1 && !r_s1_final) begin
            n_abort = 1'b1;
        end
        if (take_in && nsz != '0) begin
            if (final_e) begin
                n_row = '0;
                n_col = '0;
            end else if (r_upper) begin
                if (r_row < r_col) begin
                    n_row = r_row + 1'b1;
                end else begin
                    n_row = '0;
                    n_col = r_col + 1'b1;
                end
            end else begin
                if (r_row < nsz - 1'b1) begin
                    n_row = r_row + 1'b1;
                end else begin
                    n_row = r_col + 1'b1;
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    assign ovf1 = (r_s1_d[62:0] > tfc_pkg::F64FltMax) && (r_s1_d[62:0] <= tfc_pkg::F64Inf);

    // abort seen by stage 1 must also include one being set by the item ahead
    logic s1_dead;
    logic r_s1_dead;
    assign s1_dead = r_s1_dead;

    always_comb begin
        conv.single_bits = ovf1 ? 32'd0 : tfc_pkg::f64_to_f32(r_s1_d);
        conv.status      = ovf1;
        conv.last        = ovf1 || r_s1_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper   <= 1'b1;
            r_size    <= '0;
            r_row     <= '0;
            r_col     <= '0;
            r_abort   <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s1_dead <= 1'b0;
            r_o_v     <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_index == tfc_pkg::RegUpperSelect ||
                             i_cfg_index == tfc_pkg::RegMatrixSize)) begin
                if (i_cfg_index == tfc_pkg::RegUpperSelect) begin
                    r_upper <= i_cfg_data[0];
                end else begin
                    r_size <= i_cfg_data;
                end
                r_row   <= '0;
                r_col   <= '0;
                r_abort <= 1'b0;
            end else begin
                r_row   <= n_row;
                r_col   <= n_col;
                r_abort <= n_abort;
                if (take_in && nsz != '0 && final_e) begin
                    r_abort <= 1'b0;
                end
            end
            if (take_in) begin
                r_s1_v <= nsz != '0;
            end else if (adv1) begin
                r_s1_v <= 1'b0;
            end
            if (take_in) begin
                r_s1_dead <= r_abort || (r_s1_v && adv1 && !r_s1_dead && ovf1 && !r_s1_final);
            end
            if (adv1) begin
                r_o_v <= r_s1_v && !s1_dead;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_s1_d     <= i_element_bits;
            r_s1_row   <= r_row[9:0];
            r_s1_col   <= r_col[9:0];
            r_s1_final <= final_e;
        end
        if (adv1 && r_s1_v) begin
            o_single_bits <= conv.single_bits;
            o_row_index   <= r_s1_row;
            o_col_index   <= r_s1_col;
            o_status      <= conv.status;
            o_last        <= conv.last;
        end
    end

    assign o_valid = r_o_v;
endmodule

>>> rtl/tfc_checker.sv
// Port-level checker for the triangular converter, bound to the top level.
// Uses only the top level's ports.
module tfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_single_bits,
    input logic        o_status,
    input logic        o_last
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("valid dropped");
    a_ovf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last) else $error("overflow not last");
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_single_bits == 32'd0) else $error("overflow data");
endmodule

bind triangular_f64_to_f32_convert tfc_checker u_tfc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall),
    .o_single_bits(o_single_bits), .o_status(o_status), .o_last(o_last)
);
